[design/whc_pkg.sv]
// Shared types and constants of the word length histogram compare block.
`default_nettype none
package whc_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_BUCKET_PCT = 2'd0;
  localparam logic [1:0] REG_FAIL_LIMIT = 2'd1;
  localparam logic [1:0] REG_TOTAL_PCT  = 2'd2;

  localparam logic [7:0] RST_BUCKET_PCT = 8'd10;
  localparam logic [4:0] RST_FAIL_LIMIT = 5'd2;
  localparam logic [7:0] RST_TOTAL_PCT  = 8'd5;

  localparam logic [1:0] REASON_MATCH   = 2'd0;
  localparam logic [1:0] REASON_BUCKETS = 2'd1;
  localparam logic [1:0] REASON_TOTAL   = 2'd2;

  localparam logic [6:0] PCT_SCALE = 7'd100;

  typedef struct packed {
    logic        op;
    logic [15:0] word_length;
    logic [31:0] ref_count;
  } in_item_t;

  typedef struct packed {
    logic       is_match;
    logic [1:0] reason;
  } out_item_t;

  typedef struct packed {
    logic [7:0] bucket_pct;
    logic [4:0] fail_limit;
    logic [7:0] total_pct;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic cmp_rd;
    logic add_div;
    logic add_rd;
    logic add_wr;
    logic cmp_ds;
    logic cmp_mul;
    logic cmp_chk;
    logic tot_load;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

[design/whc_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module whc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[design/whc_regs.sv]
// APB configuration registers of the histogram compare block.
`default_nettype none
module whc_regs
  import whc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bucket_pct <= RST_BUCKET_PCT;
      cfg_q.fail_limit <= RST_FAIL_LIMIT;
      cfg_q.total_pct  <= RST_TOTAL_PCT;
    end else if (wr_en) begin
      case (idx)
        REG_BUCKET_PCT: cfg_q.bucket_pct <= pwdata[7:0];
        REG_FAIL_LIMIT: cfg_q.fail_limit <= pwdata[4:0];
        REG_TOTAL_PCT:  cfg_q.total_pct  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BUCKET_PCT: prdata = {24'd0, cfg_q.bucket_pct};
      REG_FAIL_LIMIT: prdata = {27'd0, cfg_q.fail_limit};
      REG_TOTAL_PCT:  prdata = {24'd0, cfg_q.total_pct};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[design/whc_ctrl.sv]
// Controller state machine sequencing add-word and compare requests.
`default_nettype none
module whc_ctrl
  import whc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  status_t   status_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_DIV,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_CMP_DS,
    ST_CMP_MUL,
    ST_CMP_CHK,
    ST_TOT_CHK
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.cmp_rd   = accept & status_i.in_op;
    cmd_o.add_div  = (state_q == ST_ADD_DIV);
    cmd_o.add_rd   = (state_q == ST_ADD_RD);
    cmd_o.add_wr   = (state_q == ST_ADD_WR);
    cmd_o.cmp_ds   = (state_q == ST_CMP_DS);
    cmd_o.cmp_mul  = (state_q == ST_CMP_MUL);
    cmd_o.cmp_chk  = (state_q == ST_CMP_CHK);
    cmd_o.tot_load = (state_q == ST_TOT_CHK) & ~status_i.out_busy;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = status_i.in_op ? ST_CMP_DS : ST_ADD_DIV;
        end
      end
      ST_ADD_DIV: state_d = ST_ADD_RD;
      ST_ADD_RD:  state_d = ST_ADD_WR;
      ST_ADD_WR:  state_d = ST_IDLE;
      ST_CMP_DS:  state_d = ST_CMP_MUL;
      ST_CMP_MUL: state_d = ST_CMP_CHK;
      ST_CMP_CHK: state_d = status_i.last ? ST_TOT_CHK : ST_IDLE;
      ST_TOT_CHK: begin
        // hold until the output slot frees up
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[design/whc_dp.sv]
// Datapath: bucket store, bucket index reduction, tolerance checks, result register.
`default_nettype none
module whc_dp
  import whc_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  in_item_t  in_data_i,
  input  cfg_t      cfg_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BUCKETS);
  localparam longint unsigned RecipL =
      ((64'd1 << 32) + NUM_BUCKETS - 1) / NUM_BUCKETS;
  localparam logic [31:0] Recip    = RecipL[31:0];
  localparam logic [15:0] NumB16   = 16'(NUM_BUCKETS);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_BUCKETS - 1);
  localparam logic [39:0] SumMax   = '1;
  localparam logic [31:0] CountMax = '1;

  in_item_t         in_q;
  logic [47:0]      quot_prod_q;
  logic [15:0]      quot;
  logic [31:0]      qn;
  logic [15:0]      rem;
  logic [IDX_W-1:0] rem_idx;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] rd_addr_q;
  logic             ram_re;
  logic [31:0]      rdata;
  logic [31:0]      mine;
  logic [31:0]      inc;
  logic [NUM_BUCKETS-1:0] valid_q;

  logic [IDX_W-1:0] cmp_idx_q;
  logic [31:0]      d_q;
  logic [32:0]      s_q;
  logic [38:0]      pd_q;
  logic [40:0]      ps_q;
  logic [39:0]      diff_sum_q;
  logic [39:0]      scale_sum_q;
  logic [40:0]      diff_add;
  logic [40:0]      scale_add;
  logic [46:0]      ptd_q;
  logic [47:0]      pts_q;
  logic [4:0]       failed_q;
  logic [5:0]       failed_next;
  logic             too_many_q;
  logic             bucket_fail;
  logic             total_fail;

  logic             out_valid_q;
  out_item_t        out_q;

  // bucket index = word_length mod NUM_BUCKETS via reciprocal multiply
  assign quot    = quot_prod_q[47:32];
  assign qn      = quot * NumB16;
  assign rem     = in_q.word_length - qn[15:0];
  assign rem_idx = rem[IDX_W-1:0];

  assign ram_re = cmd_i.cmp_rd | cmd_i.add_rd;
  assign raddr  = cmd_i.add_rd ? rem_idx : cmp_idx_q;

  assign mine = valid_q[rd_addr_q] ? rdata : '0;
  assign inc  = (mine == CountMax) ? mine : mine + 32'd1;

  whc_ram #(
    .WIDTH(32),
    .DEPTH(NUM_BUCKETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.add_wr),
    .waddr_i(rd_addr_q),
    .wdata_i(inc),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q <= in_data_i;
    end
    if (cmd_i.add_div) begin
      quot_prod_q <= {32'd0, in_q.word_length} * {16'd0, Recip};
    end
    if (ram_re) begin
      rd_addr_q <= raddr;
    end
    if (cmd_i.cmp_ds) begin
      d_q <= (mine >= in_q.ref_count) ? mine - in_q.ref_count : in_q.ref_count - mine;
      s_q <= {1'b0, mine} + {1'b0, in_q.ref_count};
    end
    if (cmd_i.cmp_mul) begin
      pd_q <= {7'd0, d_q} * 39'(PCT_SCALE);
      ps_q <= {8'd0, s_q} * {33'd0, cfg_i.bucket_pct};
    end
    if (cmd_i.cmp_chk) begin
      ptd_q <= {7'd0, diff_sum_q} * 47'(PCT_SCALE);
      pts_q <= {8'd0, scale_sum_q} * {40'd0, cfg_i.total_pct};
    end
  end

  assign diff_add    = {1'b0, diff_sum_q} + {9'd0, d_q};
  assign scale_add   = {1'b0, scale_sum_q} + {8'd0, s_q};
  assign bucket_fail = {2'd0, pd_q} > ps_q;
  assign total_fail  = {1'b0, ptd_q} > pts_q;
  assign failed_next = {1'b0, failed_q} + 6'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cmp_idx_q   <= '0;
      diff_sum_q  <= '0;
      scale_sum_q <= '0;
      failed_q    <= '0;
      too_many_q  <= 1'b0;
    end else begin
      if (cmd_i.add_wr) begin
        valid_q[rd_addr_q] <= 1'b1;
      end
      if (cmd_i.cmp_mul) begin
        // saturate the totals instead of wrapping
        diff_sum_q  <= diff_add[40] ? SumMax : diff_add[39:0];
        scale_sum_q <= scale_add[40] ? SumMax : scale_add[39:0];
      end
      if (cmd_i.cmp_chk) begin
        cmp_idx_q <= (cmp_idx_q == LastIdx) ? '0 : cmp_idx_q + IDX_W'(1);
        if (bucket_fail) begin
          if (failed_next > {1'b0, cfg_i.fail_limit}) begin
            too_many_q <= 1'b1;
          end
          failed_q <= failed_next[5] ? 5'd31 : failed_next[4:0];
        end
      end
      if (cmd_i.tot_load) begin
        diff_sum_q  <= '0;
        scale_sum_q <= '0;
        failed_q    <= '0;
        too_many_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tot_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tot_load) begin
      if (too_many_q) begin
        out_q.reason <= REASON_BUCKETS;
      end else if (total_fail) begin
        out_q.reason <= REASON_TOTAL;
      end else begin
        out_q.reason <= REASON_MATCH;
      end
      out_q.is_match <= ~too_many_q & ~total_fail;
    end
  end

  assign status_o.in_op    = in_data_i.op;
  assign status_o.last     = (cmp_idx_q == LastIdx);
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[design/word_length_histogram_compare.sv]
// An add-word request passes the states ADD_DIV, ADD_RD and ADD_WR before ready rises again.
// A compare request passes CMP_DS, CMP_MUL and CMP_CHK; the one carrying the last bucket
// also passes TOT_CHK, which loads its result into the output register, and waits there
// while an earlier result is still waiting. One request is worked on at a time,
// as the controller takes a new one only while it is idle.
// Reset clears all buckets at once through per-entry valid bits; registers reset to 10, 2, 5.
`default_nettype none
module word_length_histogram_compare
  import whc_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  in_item_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  whc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  whc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  whc_dp #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

[design/whc_checker.sv]
// Port-level checks of the histogram compare block and their bind.
`default_nettype none
module whc_props
  import whc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // the block is not ready in the cycle after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  // a new result only appears while a request is being worked on
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a request in flight");

  // reason code is in range and the match flag agrees with it
  a_reason_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.reason <= REASON_TOTAL) &&
                    (out_data_o.is_match == (out_data_o.reason == REASON_MATCH)))
    else $error("match flag and reason disagree");

endmodule

bind word_length_histogram_compare whc_props u_whc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

[dv/whc_tb_pkg.sv]
// Request opcodes shared by the histogram compare testbench files.
`timescale 1ns / 100ps
package whc_tb_pkg;

  typedef enum logic {
    OP_ADD_WORD = 1'b0,
    OP_COMPARE  = 1'b1
  } req_op_e;

endpackage

[dv/whc_checker.sv]
// Checker that predicts histogram compare verdicts and matches them against the block.
`timescale 1ns / 100ps
module whc_checker
  import whc_pkg::*;
  import whc_tb_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  in_item_t                   in_data_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  out_item_t                  out_data_i,
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic                  pready_i,
  input  wire logic [APB_ADDR_W-1:0] paddr_i,
  input  wire logic [APB_DATA_W-1:0] pwdata_i,
  output int unsigned                pending_o,
  output int unsigned                errors_o
);

  localparam logic [39:0] SUM_SAT  = '1;
  localparam logic [4:0]  FAIL_SAT = '1;

  logic [31:0] hist [NUM_BUCKETS];
  int unsigned cmp_idx;
  logic [4:0]  fails;
  logic [39:0] diff_acc;
  logic [39:0] scale_acc;
  logic        over_limit;

  logic [7:0]  bucket_pct;
  logic [4:0]  fail_limit;
  logic [7:0]  total_pct;

  out_item_t   verdict_q [$];

  function automatic logic [39:0] sat_sum(input logic [39:0] acc, input logic [63:0] inc);
    logic [63:0] sum;
    sum = {24'd0, acc} + inc;
    return (sum > {24'd0, SUM_SAT}) ? SUM_SAT : sum[39:0];
  endfunction

  task automatic clear_compare();
    cmp_idx    = 0;
    fails      = '0;
    diff_acc   = '0;
    scale_acc  = '0;
    over_limit = 1'b0;
  endtask

  task automatic predict_request(input in_item_t req);
    int unsigned b;
    logic [63:0] mine;
    logic [63:0] theirs;
    logic [63:0] diff;
    logic [63:0] scale;
    logic [63:0] bound;
    logic [5:0]  next;
    out_item_t   verdict;
    if (req.op == OP_ADD_WORD) begin
      b = req.word_length % NUM_BUCKETS;
      if (hist[b] != '1) hist[b] = hist[b] + 32'd1;
      return;
    end
    b      = cmp_idx % NUM_BUCKETS;
    mine   = {32'd0, hist[b]};
    theirs = {32'd0, req.ref_count};
    diff   = (mine >= theirs) ? mine - theirs : theirs - mine;
    scale  = mine + theirs;
    bound  = 64'd1 + (scale * bucket_pct) / PCT_SCALE;
    if (diff >= bound) begin
      // take the too-many decision before the count saturates
      next = {1'b0, fails} + 6'd1;
      if (next > {1'b0, fail_limit}) over_limit = 1'b1;
      fails = (next > {1'b0, FAIL_SAT}) ? FAIL_SAT : next[4:0];
    end
    diff_acc  = sat_sum(diff_acc, diff);
    scale_acc = sat_sum(scale_acc, scale);
    if (b + 1 < NUM_BUCKETS) begin
      cmp_idx = b + 1;
      return;
    end
    bound = 64'd1 + ({24'd0, scale_acc} * total_pct) / PCT_SCALE;
    if (over_limit) begin
      verdict.reason = REASON_BUCKETS;
    end else if ({24'd0, diff_acc} >= bound) begin
      verdict.reason = REASON_TOTAL;
    end else begin
      verdict.reason = REASON_MATCH;
    end
    verdict.is_match = (verdict.reason == REASON_MATCH);
    verdict_q.push_back(verdict);
    clear_compare();
  endtask

  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      $error("unexpected verdict: is_match %0d reason %0d", got.is_match, got.reason);
      errors_o++;
      return;
    end
    want = verdict_q.pop_front();
    if (got.is_match !== want.is_match) begin
      $error("is_match: expected %0d, actual %0d", want.is_match, got.is_match);
      errors_o++;
    end
    if (got.reason !== want.reason) begin
      $error("reason: expected %0d, actual %0d", want.reason, got.reason);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hist[i]) hist[i] = '0;
      clear_compare();
      bucket_pct = RST_BUCKET_PCT;
      fail_limit = RST_FAIL_LIMIT;
      total_pct  = RST_TOTAL_PCT;
      verdict_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_verdict(out_data_i);
      if (in_valid_i && in_ready_i) predict_request(in_data_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_BUCKET_PCT: bucket_pct = pwdata_i[7:0];
          REG_FAIL_LIMIT: fail_limit = pwdata_i[4:0];
          REG_TOTAL_PCT:  total_pct  = pwdata_i[7:0];
          default: ;
        endcase
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

[dv/testbench.sv]
// Top of the histogram compare testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module testbench;
  import whc_pkg::*;
  import whc_tb_pkg::*;

  localparam int unsigned NUM_BUCKETS    = 16;
  localparam int unsigned ITEM_TARGET    = 1300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [1:0]  REG_SPARE      = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned pending;
  int unsigned errors;

  // sender bookkeeping: bucket tallies steer reference counts near the real ones
  int unsigned tally [NUM_BUCKETS];
  int unsigned items_sent;
  bit          tx_calm;

  // receiver state
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned verdicts_taken;
  int unsigned verdicts_seen;

  int unsigned quiet_cycles;

  always #2 clk_i = ~clk_i;

  word_length_histogram_compare #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  whc_checker #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // receiver: random stall per verdict, calm stretches, one long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      verdicts_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (hold_reqs != holds_done) begin
      hold_left  = HOLD_CYCLES;
      holds_done = hold_reqs;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (verdicts_taken != verdicts_seen) begin
        verdicts_seen = verdicts_taken;
        stall_left    = ((verdicts_taken / 8) % 3 == 0) ? 0 : $urandom_range(0, 18);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input req_op_e op, input logic [15:0] len,
                              input logic [31:0] refc);
    int unsigned gap;
    in_item_t    req;
    gap             = tx_calm ? 0 : $urandom_range(0, 18);
    req.op          = op;
    req.word_length = len;
    req.ref_count   = refc;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
    if (op == OP_ADD_WORD) tally[len % NUM_BUCKETS]++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold the input until every verdict is back and the last request has left the block
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_tolerances(input logic [7:0] bpct, input logic [4:0] lim,
                                input logic [7:0] tpct);
    logic [31:0] noise;
    noise = $urandom();
    write_reg(REG_BUCKET_PCT, {noise[31:8], bpct});
    write_reg(REG_FAIL_LIMIT, {noise[31:5], lim});
    write_reg(REG_TOTAL_PCT, {noise[31:8], tpct});
  endtask

  // one full compare pass, preceded by a burst of words, with words at times mixed in
  task automatic run_pass(input int unsigned n_add, input bit calm);
    int unsigned fav;
    int unsigned kind;
    int unsigned delta;
    logic [15:0] len;
    logic [31:0] refv;
    bit          clean;
    bit          mixed;
    bit          retune;
    clean   = $urandom_range(0, 1);
    mixed   = ($urandom_range(0, 5) == 0);
    retune  = ($urandom_range(0, 9) == 0);
    fav     = $urandom_range(0, NUM_BUCKETS - 1);
    tx_calm = calm || ($urandom_range(0, 3) == 0);
    repeat (n_add) begin
      len = 16'($urandom());
      if ($urandom_range(0, 1)) len = 16'(len - (len % NUM_BUCKETS) + fav);
      send_request(OP_ADD_WORD, len, $urandom());
    end
    for (int unsigned b = 0; b < NUM_BUCKETS; b++) begin
      if (retune && b == NUM_BUCKETS / 2) begin
        // retune half way through the pass while the block sits idle
        drain();
        case ($urandom_range(0, 2))
          0: write_reg(REG_BUCKET_PCT, $urandom_range(0, 255));
          1: write_reg(REG_FAIL_LIMIT, $urandom_range(0, 16));
          default: write_reg(REG_TOTAL_PCT, $urandom_range(0, 255));
        endcase
      end
      if (mixed && $urandom_range(0, 3) == 0) begin
        send_request(OP_ADD_WORD, 16'($urandom()), $urandom());
      end
      kind  = clean ? $urandom_range(0, 7) : $urandom_range(0, 9);
      delta = $urandom_range(0, 3) + tally[b] / $urandom_range(4, 16);
      case (kind)
        5, 6: refv = tally[b] + delta;
        7: refv = (tally[b] >= delta) ? tally[b] - delta : 32'd0;
        8: refv = $urandom();
        9: refv = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        default: refv = tally[b];
      endcase
      send_request(OP_COMPARE, 16'($urandom()), refv);
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed pass on reset tolerances; the spare register index must be ignored
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    tx_calm = 1'b0;
    send_request(OP_ADD_WORD, 16'd0, 32'hFFFF_FFFF);
    send_request(OP_ADD_WORD, 16'hFFFF, 32'd0);
    send_request(OP_ADD_WORD, 16'd15, 32'd0);
    send_request(OP_ADD_WORD, 16'd16, 32'd0);
    send_request(OP_ADD_WORD, 16'd17, 32'd0);
    send_request(OP_ADD_WORD, 16'h5555, 32'hAAAA_AAAA);
    send_request(OP_ADD_WORD, 16'hAAAA, 32'h5555_5555);
    // full-scale reference on bucket 0 and an empty one on bucket 1
    for (int unsigned b = 0; b < NUM_BUCKETS; b++) begin
      send_request(OP_COMPARE, 16'hFFFF,
                   (b == 0) ? 32'hFFFF_FFFF : (b == 1) ? 32'd0 : tally[b]);
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      case (phase)
        0: set_tolerances(8'd0, 5'd0, 8'd0);
        1: set_tolerances(8'd255, 5'd16, 8'd255);
        default: set_tolerances(8'($urandom_range(0, 255)), 5'($urandom_range(0, 16)),
                                8'($urandom_range(0, 255)));
      endcase
      if (phase == 2) begin
        // starve the output while passes keep arriving back to back
        hold_reqs++;
        repeat (3) run_pass(2, 1'b1);
      end
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 9) == 0) begin
          run_pass(150, 1'b0);
        end else begin
          run_pass($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 6), 1'b0);
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
